// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define CDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define CDQ_ASSERT_NEVER(lbl, cond, msg) \
  `CDQ_ASSERT(lbl, !(cond), msg)

`endif

// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// shared widths, request codes and the result flag bundle of the deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int CAP_W     = 11;
  localparam int KIND_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // request codes
  localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] K_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] K_DEL_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] K_DEL_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] K_RD_FRONT  = 3'd4;
  localparam logic [KIND_W-1:0] K_RD_REAR   = 3'd5;

  // result flags from the control stage
  typedef struct packed {
    logic ok;
    logic rd_mem;    // data comes from the ring store
    logic rd_neg;    // read of an empty deque, data is all ones
    logic is_empty;
    logic is_full;
  } res_t;

  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic int cmp_width(input int depth);
    return (idx_width(depth) + 1 > CAP_W) ? idx_width(depth) + 1 : CAP_W;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// single port ring store, one write or one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = idx_width(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// capacity register, end indices and element count; decodes one request
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = idx_width(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CAP_W-1:0]  cfg_cap,
  input  wire logic              req_vld,
  input  wire logic [KIND_W-1:0] req_kind,
  output logic                   mem_we,
  output logic      [IDX_W-1:0]  mem_addr,
  output res_t                   res
);

  localparam int CMP_W = cmp_width(DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

  logic [CAP_W-1:0] cap_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic [CAP_W-1:0] cnt_r, cnt_nxt;

  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic             empty, full;
  logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic             we_c;
  logic [IDX_W-1:0] addr_c;
  res_t             res_c;

  // capacity clamped to 1..DEPTH
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = ONE_C;
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign empty = (cnt_r == '0);
  assign full  = (CMP_W'(cnt_r) >= eff_cap);

  // wrap by comparison against the capacity
  assign front_inc = (CMP_W'(front_r) + ONE_C >= eff_cap) ? '0 : front_r + IDX_W'(1);
  assign rear_inc  = (CMP_W'(rear_r) + ONE_C >= eff_cap) ? '0 : rear_r + IDX_W'(1);
  assign front_dec = (front_r == '0 || CMP_W'(front_r) >= eff_cap) ?
                     IDX_W'(eff_cap - ONE_C) : front_r - IDX_W'(1);
  assign rear_dec  = (rear_r == '0 || CMP_W'(rear_r) >= eff_cap) ?
                     IDX_W'(eff_cap - ONE_C) : rear_r - IDX_W'(1);

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    cnt_nxt   = cnt_r;
    we_c      = 1'b0;
    addr_c    = front_r;
    res_c     = '0;
    case (req_kind)
      K_INS_FRONT, K_INS_BACK: begin
        if (!full) begin
          if (empty) begin
            front_nxt = '0;
            rear_nxt  = '0;
            addr_c    = '0;
          end else if (req_kind == K_INS_FRONT) begin
            front_nxt = front_dec;
            addr_c    = front_dec;
          end else begin
            rear_nxt = rear_inc;
            addr_c   = rear_inc;
          end
          we_c     = 1'b1;
          cnt_nxt  = cnt_r + CAP_W'(1);
          res_c.ok = 1'b1;
        end
      end
      K_DEL_FRONT: begin
        if (!empty) begin
          front_nxt = front_inc;
          cnt_nxt   = cnt_r - CAP_W'(1);
          res_c.ok  = 1'b1;
        end
      end
      K_DEL_BACK: begin
        if (!empty) begin
          rear_nxt = rear_dec;
          cnt_nxt  = cnt_r - CAP_W'(1);
          res_c.ok = 1'b1;
        end
      end
      K_RD_FRONT, K_RD_REAR: begin
        addr_c = (req_kind == K_RD_FRONT) ? front_r : rear_r;
        if (empty) begin
          res_c.rd_neg = 1'b1;
        end else begin
          res_c.rd_mem = 1'b1;
          res_c.ok     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_c.is_empty = (cnt_nxt == '0);
    res_c.is_full  = (CMP_W'(cnt_nxt) >= eff_cap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      front_r <= '0;
      rear_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
      if (req_vld) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  assign mem_we   = req_vld & we_c;
  assign mem_addr = addr_c;
  assign res      = res_c;

endmodule

`default_nettype wire

// ===== sv/circular_deque.sv =====
// a request taken at a start edge goes through the input and result registers
// throughput: one request per cycle, busy stays low in normal operation
// the single port ring store does the insert write or the registered read
// out_valid is a one-cycle strobe, the receiver cannot stall results
// reset (rst_n low, synchronous) empties the deque and sets capacity to 1024
// busy is high for the first cycle after reset, ring store is not cleared
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue in a ring store with a programmable capacity
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [KIND_W-1:0] in_kind,
  input  wire logic signed [DATA_W-1:0] in_value,
  // capacity register write
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic        [CAP_W-1:0]  cfg_data,
  // result channel
  output logic                          out_valid,
  output logic                          out_ok,
  output logic signed      [DATA_W-1:0] out_data,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  localparam int IDX_W = idx_width(DEPTH);

  // input register stage
  logic              in_vld_r;
  logic [KIND_W-1:0] in_kind_r;
  logic [DATA_W-1:0] in_value_r;
  logic              busy_r;

  // result register stage
  logic              out_valid_r;
  res_t              res_r;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res_c;

  wire logic accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      in_vld_r    <= accept;
      out_valid_r <= in_vld_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind_r  <= in_kind;
      in_value_r <= in_value;
    end
    res_r <= res_c;
  end

  // index, count and capacity logic
  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_cap  (cfg_data),
    .req_vld  (in_vld_r),
    .req_kind (in_kind_r),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .res      (res_c)
  );

  // ring store, read data lands in the same edge as the result flags
  cdq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_value_r),
    .rdata (mem_rdata)
  );

  assign busy         = busy_r;
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_ok       = res_r.ok;
  assign out_is_empty = res_r.is_empty;
  assign out_is_full  = res_r.is_full;

  // read of an empty deque gives all ones, non-read beats give zero
  always_comb begin
    if (res_r.rd_mem) begin
      out_data = mem_rdata;
    end else if (res_r.rd_neg) begin
      out_data = '1;
    end else begin
      out_data = '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_checker
// port level checks of the deque, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdq_checker
  import cdq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     out_valid,
  input wire logic                     out_ok,
  input wire logic signed [DATA_W-1:0] out_data,
  input wire logic                     out_is_empty,
  input wire logic                     out_is_full
);

  // request beat taken, failed result beat with nonzero data
  wire logic req_take = start & ~busy;
  wire logic fail_nz  = out_valid & ~out_ok & (out_data != '0);

  // every accepted request gives exactly one result beat, through the input and result registers
  `CDQ_ASSERT(a_result_follows, req_take |-> ##2 out_valid, "missing result beat")
  `CDQ_ASSERT(a_no_spurious, !req_take |-> ##2 !out_valid, "result beat without request")
  // capacity is at least one, so an empty deque is never full
  `CDQ_ASSERT_NEVER(a_empty_full, out_valid && out_is_empty && out_is_full, "empty and full")
  // a failed beat carries zero or, for a read of an empty deque, all ones
  `CDQ_ASSERT(a_fail_data, fail_nz |-> (out_data == '1 && out_is_empty), "bad fail data")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for circular_deque: a request driver fed from a queue,
// a result monitor and a request-level predictor of the deque, run through
// preload, directed corner cases and random phases over many capacities
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cdq_pkg::*;

  // kind codes the block treats as no-ops
  localparam logic [KIND_W-1:0] K_RSVD_6 = 3'd6;
  localparam logic [KIND_W-1:0] K_RSVD_7 = 3'd7;

  localparam int N_PHASES   = 10;
  localparam int PHASE_LEN  = 68;
  localparam int MAX_SHOWN  = 10;
  localparam int TAIL_CYC   = 10;
  // low slots written up front, small capacities stay inside them
  localparam int PRELOAD_N  = 64;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } deque_req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
    logic                     is_empty;
    logic                     is_full;
  } deque_res_t;

  // dut ports, all inputs known from time zero
  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     start        = 1'b0;
  logic                     busy;
  logic        [KIND_W-1:0] in_kind      = '0;
  logic signed [DATA_W-1:0] in_value     = '0;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic        [CAP_W-1:0]  cfg_data     = '0;
  logic                     out_valid;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_is_empty;
  logic                     out_is_full;

  // requests still to be sent and results still to come
  deque_req_t req_pending[$];
  deque_res_t res_expected[$];

  // sender gap rate in percent, changed between phases
  int unsigned gap_pct = 11;
  int unsigned err_cnt = 0;

  // predictor state
  logic [DATA_W-1:0] ring_mdl[DEPTH_DEF];
  int unsigned       front_mdl = 0;
  int unsigned       rear_mdl  = 0;
  int unsigned       count_mdl = 0;
  logic [CAP_W-1:0]  cap_mdl   = CAP_RESET;

  circular_deque i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_data     (out_data),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // register value as the block uses it: zero acts as one, saturate at depth
  function automatic int unsigned used_capacity();
    if (cap_mdl == 0) return 1;
    if (cap_mdl > DEPTH_DEF) return DEPTH_DEF;
    return 32'(cap_mdl);
  endfunction

  // wrap by compare, an index left beyond a shrunk capacity goes to 0
  function automatic int unsigned ring_next(input int unsigned idx, input int unsigned cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  // stepping back from 0 or from beyond the capacity lands on the last slot
  function automatic int unsigned ring_prev(input int unsigned idx, input int unsigned cap);
    if (idx == 0 || idx >= cap) return cap - 1;
    return idx - 1;
  endfunction

  // apply one request to the predictor and return the result it must give
  function automatic deque_res_t deque_apply(input logic [KIND_W-1:0] kind,
                                             input logic [DATA_W-1:0] val);
    int unsigned cap;
    bit          was_empty;
    bit          was_full;
    deque_res_t  r;
    cap       = used_capacity();
    was_empty = (count_mdl == 0);
    was_full  = (count_mdl >= cap);
    r         = '0;
    case (kind)
      K_INS_FRONT, K_INS_BACK: begin
        if (!was_full) begin
          // first element re-anchors both ends at slot 0
          if (was_empty) begin
            front_mdl = 0;
            rear_mdl  = 0;
          end else if (kind == K_INS_FRONT) begin
            front_mdl = ring_prev(front_mdl, cap);
          end else begin
            rear_mdl = ring_next(rear_mdl, cap);
          end
          ring_mdl[(kind == K_INS_FRONT) ? front_mdl : rear_mdl] = val;
          count_mdl++;
          r.ok = 1'b1;
        end
      end
      K_DEL_FRONT: begin
        if (!was_empty) begin
          front_mdl = ring_next(front_mdl, cap);
          count_mdl--;
          r.ok = 1'b1;
        end
      end
      K_DEL_BACK: begin
        if (!was_empty) begin
          rear_mdl = ring_prev(rear_mdl, cap);
          count_mdl--;
          r.ok = 1'b1;
        end
      end
      K_RD_FRONT, K_RD_REAR: begin
        if (was_empty) begin
          r.data = '1;
        end else begin
          r.data = ring_mdl[(kind == K_RD_FRONT) ? front_mdl : rear_mdl];
          r.ok   = 1'b1;
        end
      end
      default: begin
        // reserved kinds leave the state alone
      end
    endcase
    r.is_empty = (count_mdl == 0);
    r.is_full  = (count_mdl >= cap);
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // driver: one request beat per start edge with busy low
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : drv_blk
    deque_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // beat taken at this edge, predict it now
      if (start && !busy) begin
        res_expected.push_back(deque_apply(in_kind, in_value));
      end
      // hold the request while busy, otherwise pick the next one or a gap
      if (!start || !busy) begin
        if (req_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt      = req_pending.pop_front();
          start    <= 1'b1;
          in_kind  <= nxt.kind;
          in_value <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // monitor: every strobed result is checked against the oldest prediction
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : mon_blk
    deque_res_t want;
    if (rst_n && out_valid) begin
      if (res_expected.size() == 0) begin
        if (err_cnt < MAX_SHOWN) begin
          $display("unexpected result: ok=%0b data=%0d empty=%0b full=%0b",
                   out_ok, out_data, out_is_empty, out_is_full);
        end
        err_cnt++;
      end else begin
        want = res_expected.pop_front();
        if (out_ok !== want.ok || out_data !== want.data ||
            out_is_empty !== want.is_empty || out_is_full !== want.is_full) begin
          if (err_cnt < MAX_SHOWN) begin
            $display("result mismatch at %0t: ok %0b/%0b data %0d/%0d empty %0b/%0b full %0b/%0b",
                     $realtime, want.ok, out_ok, want.data, out_data,
                     want.is_empty, out_is_empty, want.is_full, out_is_full);
          end
          err_cnt++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  task automatic queue_req(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] val);
    deque_req_t r;
    r.kind  = kind;
    r.value = val;
    req_pending.push_back(r);
  endtask

  // poll at the falling edge so the queues are stable when looked at
  task automatic wait_drained();
    do @(negedge clk);
    while (req_pending.size() != 0 || start || res_expected.size() != 0);
  endtask

  // delete every held element, called with nothing in flight
  task automatic drain_deque();
    int unsigned n;
    n = count_mdl;
    for (int unsigned i = 0; i < n; i++) begin
      queue_req(K_DEL_BACK, '0);
    end
    wait_drained();
  endtask

  // capacity write, only issued while nothing is in flight
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    cap_mdl   = cap;
  endtask

  // random mix: ins_pct percent inserts, a little reserved-kind noise,
  // the rest split over deletes and reads
  task automatic queue_random(input int n, input int unsigned ins_pct);
    int unsigned r;
    logic [KIND_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        k = $urandom_range(1) ? K_RSVD_7 : K_RSVD_6;
      end else if (r < 4 + ins_pct) begin
        k = $urandom_range(1) ? K_INS_BACK : K_INS_FRONT;
      end else begin
        case ($urandom_range(5))
          0, 1:    k = K_DEL_FRONT;
          2, 3:    k = K_DEL_BACK;
          4:       k = K_RD_FRONT;
          default: k = K_RD_REAR;
        endcase
      end
      queue_req(k, $urandom);
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin : stim_blk
    logic [CAP_W-1:0] phase_cap[N_PHASES];
    int unsigned      phase_ins[N_PHASES];
    phase_cap = '{11'd1024, 11'd5, 11'd1, 11'd37, 11'd0,
                  11'd2047, 11'd3, 11'd1025, 11'd16, 11'd2};
    phase_ins = '{70, 40, 50, 55, 45, 60, 35, 50, 50, 50};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // preload: fill the low slots so every slot a small capacity can reach
    // holds a known value, two extra inserts hit the full deque, then
    // empty it again with some reads mixed in
    write_capacity(CAP_W'(PRELOAD_N));
    for (int i = 0; i < PRELOAD_N + 2; i++) begin
      queue_req($urandom_range(1) ? K_INS_BACK : K_INS_FRONT, $urandom);
    end
    for (int i = 0; i < PRELOAD_N + 2; i++) begin
      if ($urandom_range(7) == 0) begin
        queue_req($urandom_range(1) ? K_RD_REAR : K_RD_FRONT, $urandom);
      end
      queue_req($urandom_range(1) ? K_DEL_BACK : K_DEL_FRONT, $urandom);
    end
    wait_drained();

    // capacity zero acts as a single slot
    write_capacity(11'd0);
    queue_req(K_INS_BACK,  32'h7fff_ffff);  // fills it
    queue_req(K_INS_FRONT, 32'h0000_0001);  // full, rejected
    queue_req(K_RD_FRONT,  32'h0);
    queue_req(K_RD_REAR,   32'hffff_ffff);
    queue_req(K_DEL_BACK,  32'h0);
    queue_req(K_DEL_FRONT, 32'h0);          // empty, rejected
    queue_req(K_DEL_BACK,  32'h0);          // empty, rejected
    queue_req(K_RD_FRONT,  32'h0);          // empty read gives all ones
    queue_req(K_RD_REAR,   32'h0);
    queue_req(K_RSVD_6,    32'h5555_5555);
    queue_req(K_RSVD_7,    32'haaaa_aaaa);
    queue_req(K_INS_FRONT, 32'h8000_0000);
    queue_req(K_RD_REAR,   32'h0);
    wait_drained();

    // oversize capacity saturates at depth, element kept across the write,
    // front insert wraps to the top slot
    write_capacity(11'd2047);
    queue_req(K_INS_FRONT, 32'hffff_ffff);
    queue_req(K_INS_BACK,  32'h0000_0000);
    queue_req(K_RD_FRONT,  32'h0);
    queue_req(K_RD_REAR,   32'h0);
    queue_req(K_DEL_FRONT, 32'h0);
    queue_req(K_DEL_BACK,  32'h0);
    queue_req(K_RD_FRONT,  32'h0);
    queue_req(K_RSVD_7,    32'h0);
    wait_drained();

    // random phases; a change to a capacity inside the preloaded slots
    // lands while elements are still held, a larger one starts empty;
    // sender gaps: 11 percent, then 65 percent, then none
    for (int p = 0; p < N_PHASES; p++) begin
      gap_pct = (p < 4) ? 11 : (p < 7) ? 65 : 0;
      if (phase_cap[p] > PRELOAD_N) begin
        drain_deque();
      end
      write_capacity(phase_cap[p]);
      queue_random(PHASE_LEN, phase_ins[p]);
      wait_drained();
    end

    // latency tail, then anything still expected is a failure
    repeat (TAIL_CYC) @(posedge clk);
    if (res_expected.size() != 0) begin
      if (err_cnt < MAX_SHOWN) begin
        $display("%0d results never arrived", res_expected.size());
      end
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("** circular_deque: PASSED **");
    end else begin
      $display("** circular_deque: FAILED **");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("** circular_deque: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
